// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker of this block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is low
`define SIP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sip: assertion failed");

// same, with a caller message
`define SIP_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

`endif

// File: sv/sip_pkg.sv
// ----------------------------------------------------------------------------
// sip_pkg
// types, widths and codes of the sorted insert priority table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sip_pkg;

  // table size and stored key width
  localparam int unsigned Depth   = 16;
  localparam int unsigned KeyBits = 16;

  // beat field widths
  localparam int unsigned ActionW = 1;
  localparam int unsigned KeyW    = 16;
  localparam int unsigned TagW    = 16;
  localparam int unsigned RankW   = 4;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  // derived widths
  localparam int unsigned StoreKeyW = (KeyBits < KeyW) ? KeyBits : KeyW;
  localparam int unsigned IdxW      = $clog2(Depth);
  localparam int unsigned CntW      = $clog2(Depth + 1);
  localparam int unsigned CmpW      = (CntW > RankW) ? CntW : RankW;

  typedef enum logic [ActionW-1:0] {
    ActInsert = 1'b0,
    ActRead   = 1'b1
  } action_e;

  typedef enum logic [StatusW-1:0] {
    StOk     = 2'd0,
    StFull   = 2'd1,
    StAbsent = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    insert_en;
    logic    read_hit;
    status_e status;
  } sip_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic rank_ok;
  } sip_dp_stat_t;

endpackage

`default_nettype wire

// File: sv/sip_if.sv
// ----------------------------------------------------------------------------
// sip_if
// valid/ready channels carrying request and result beats
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sip_in_if;
  import sip_pkg::*;

  logic                valid;
  logic                ready;
  logic [ActionW-1:0]  action;
  logic [KeyW-1:0]     insert_key;
  logic [TagW-1:0]     insert_tag;
  logic [RankW-1:0]    read_rank;
  logic                batch_last;

  modport source (
    output valid, action, insert_key, insert_tag, read_rank, batch_last,
    input  ready
  );
  modport sink (
    input  valid, action, insert_key, insert_tag, read_rank, batch_last,
    output ready
  );
endinterface

interface sip_out_if;
  import sip_pkg::*;

  logic                valid;
  logic                ready;
  logic [StatusW-1:0]  status;
  logic [KeyW-1:0]     found_key;
  logic [TagW-1:0]     found_tag;
  logic [CountW-1:0]   entry_count;
  logic                batch_done;

  modport source (
    output valid, status, found_key, found_tag, entry_count, batch_done,
    input  ready
  );
  modport sink (
    input  valid, status, found_key, found_tag, entry_count, batch_done,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/sorted_insert_priority_table.sv
// result: a result beat is valid in the cycle after its request beat is taken
// throughput: one request per cycle while each result beat is taken as it shows; the
//   compare and shift insert over all entries is combinational, the result register holds one entry
// reset: clears the entry count and the result valid; entry storage is not
//   cleared and only ever read below the count
// ----------------------------------------------------------------------------
// sorted_insert_priority_table
// ascending-key table with insert by key and read by rank
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_insert_priority_table (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sip_in_if.sink     in_i,
  sip_out_if.source  out_o
);
  import sip_pkg::*;

  sip_cmd_t     cmd;
  sip_dp_stat_t dp_stat;

  sip_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .dp_stat_i   (dp_stat),
    .cmd_o       (cmd)
  );

  sip_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .insert_key_i  (in_i.insert_key),
    .insert_tag_i  (in_i.insert_tag),
    .read_rank_i   (in_i.read_rank),
    .batch_last_i  (in_i.batch_last),
    .dp_stat_o     (dp_stat),
    .status_o      (out_o.status),
    .found_key_o   (out_o.found_key),
    .found_tag_o   (out_o.found_tag),
    .entry_count_o (out_o.entry_count),
    .batch_done_o  (out_o.batch_done)
  );

endmodule

`default_nettype wire

// File: sv/sip_ctrl.sv
// ----------------------------------------------------------------------------
// sip_ctrl
// handshake controller: accepts request beats, decodes them into datapath
// commands and holds the result beat until it is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sip_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic [sip_pkg::ActionW-1:0] in_action_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  input  wire sip_pkg::sip_dp_stat_t  dp_stat_i,
  output sip_pkg::sip_cmd_t           cmd_o
);
  import sip_pkg::*;

  typedef enum logic {
    StIdle,
    StHold
  } state_e;

  state_e  state_q, state_d;
  logic    accept;
  action_e action;

  // output register frees up in the same cycle it is drained
  assign in_ready_o  = (state_q == StIdle) || out_ready_i;
  assign out_valid_o = (state_q == StHold);
  assign accept      = in_valid_i && in_ready_o;
  assign action      = action_e'(in_action_i);

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept;
    cmd_o.status    = StOk;
    unique case (action)
      ActInsert: begin
        cmd_o.insert_en = accept && !dp_stat_i.full;
        cmd_o.status    = dp_stat_i.full ? StFull : StOk;
      end
      ActRead: begin
        cmd_o.read_hit = dp_stat_i.rank_ok;
        cmd_o.status   = dp_stat_i.rank_ok ? StOk : StAbsent;
      end
      default: begin
        cmd_o.status = StOk;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) state_d = StHold;
      end
      StHold: begin
        if (out_ready_i && !accept) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/sip_datapath.sv
// ----------------------------------------------------------------------------
// sip_datapath
// sorted entry store with parallel key compare, shift insert,
// rank read and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sip_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire sip_pkg::sip_cmd_t           cmd_i,
  input  wire logic [sip_pkg::KeyW-1:0]    insert_key_i,
  input  wire logic [sip_pkg::TagW-1:0]    insert_tag_i,
  input  wire logic [sip_pkg::RankW-1:0]   read_rank_i,
  input  wire logic                        batch_last_i,
  output sip_pkg::sip_dp_stat_t            dp_stat_o,
  output logic [sip_pkg::StatusW-1:0]      status_o,
  output logic [sip_pkg::KeyW-1:0]         found_key_o,
  output logic [sip_pkg::TagW-1:0]         found_tag_o,
  output logic [sip_pkg::CountW-1:0]       entry_count_o,
  output logic                             batch_done_o
);
  import sip_pkg::*;

  logic [StoreKeyW-1:0] keys_q [Depth];
  logic [StoreKeyW-1:0] keys_d [Depth];
  logic [TagW-1:0]      tags_q [Depth];
  logic [TagW-1:0]      tags_d [Depth];
  logic [CntW-1:0]      count_q, count_d;
  logic [Depth-1:0]     lt;
  logic [StoreKeyW-1:0] key_in;
  logic [IdxW-1:0]      rd_idx;

  logic [StatusW-1:0]   status_q;
  logic [KeyW-1:0]      found_key_q;
  logic [TagW-1:0]      found_tag_q;
  logic [CountW-1:0]    entry_count_q;
  logic                 batch_done_q;

  assign key_in = insert_key_i[StoreKeyW-1:0];
  assign rd_idx = IdxW'(read_rank_i);

  assign dp_stat_o.full    = (count_q == CntW'(Depth));
  assign dp_stat_o.rank_ok = (CmpW'(read_rank_i) < CmpW'(count_q));

  // lt marks live entries that stay ahead of the new key
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      lt[i] = (CntW'(i) < count_q) && (keys_q[i] < key_in);
    end
  end

  // new entry lands at the first slot not marked, the rest shift up by one
  always_comb begin
    keys_d[0] = lt[0] ? keys_q[0] : key_in;
    tags_d[0] = lt[0] ? tags_q[0] : insert_tag_i;
    for (int i = 1; i < Depth; i++) begin
      if (lt[i]) begin
        keys_d[i] = keys_q[i];
        tags_d[i] = tags_q[i];
      end else if (lt[i-1]) begin
        keys_d[i] = key_in;
        tags_d[i] = insert_tag_i;
      end else begin
        keys_d[i] = keys_q[i-1];
        tags_d[i] = tags_q[i-1];
      end
    end
  end

  assign count_d = cmd_i.insert_en ? count_q + CntW'(1) : count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert_en) begin
      keys_q <= keys_d;
      tags_q <= tags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // result beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q      <= cmd_i.status;
      found_key_q   <= cmd_i.read_hit ? KeyW'(keys_q[rd_idx]) : '0;
      found_tag_q   <= cmd_i.read_hit ? tags_q[rd_idx] : '0;
      entry_count_q <= CountW'(count_d);
      batch_done_q  <= batch_last_i;
    end
  end

  assign status_o      = status_q;
  assign found_key_o   = found_key_q;
  assign found_tag_o   = found_tag_q;
  assign entry_count_o = entry_count_q;
  assign batch_done_o  = batch_done_q;

endmodule

`default_nettype wire

// File: sv/sip_checker.sv
// ----------------------------------------------------------------------------
// sip_checker
// port-level checks of the sorted insert priority table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sip_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_ready_i,
  input  wire logic [sip_pkg::StatusW-1:0]   status_i,
  input  wire logic [sip_pkg::KeyW-1:0]      found_key_i,
  input  wire logic [sip_pkg::TagW-1:0]      found_tag_i,
  input  wire logic [sip_pkg::CountW-1:0]    entry_count_i
);
  import sip_pkg::*;

  // a waiting result is held until taken
  `SIP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)

  // each taken request shows its result on the next cycle
  `SIP_ASSERT(a_result_next, clk_i, rst_ni, in_valid_i && in_ready_i |=> out_valid_i)

  // a dropped insert only happens with a full table
  `SIP_ASSERT_MSG(a_full_count, clk_i, rst_ni,
    out_valid_i && (status_i == StFull) |-> entry_count_i == CountW'(Depth),
    "sip: full status with table not full")

  // entry data only leaves with a successful read
  `SIP_ASSERT_MSG(a_found_ok, clk_i, rst_ni,
    out_valid_i && ((found_key_i != '0) || (found_tag_i != '0)) |-> status_i == StOk,
    "sip: entry data on a failed step")

endmodule

bind sorted_insert_priority_table sip_checker u_sip_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .found_key_i   (out_o.found_key),
  .found_tag_i   (out_o.found_tag),
  .entry_count_i (out_o.entry_count)
);

`default_nettype wire
